FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge, masked while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("port assertion failed");

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("port assertion failed");

`endif

FILE: rtl/cwf_pkg.sv
`timescale 1ns / 1ps

package cwf_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef enum logic {
    CMD_INIT   = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_t;

  localparam logic [15:0] FADE_PERIOD_RESET = 16'd100;
  localparam logic [6:0]  GOAL_MIN          = 7'd10;

  // Brightness is carried as percent * 2^SCALE_SHIFT / 100, rounded up,
  // so one multiply and a shift give floor(channel * percent / 100).
  localparam int          SCALE_SHIFT = 20;
  localparam int          SCALE_W     = 21;
  localparam logic [SCALE_W-1:0] SCALE_STEP = SCALE_W'(10486);

  localparam logic [7:0] SEG_1    = 8'd85;
  localparam logic [7:0] SEG_2    = 8'd170;
  localparam logic [7:0] WHEEL_END = 8'd255;
  localparam logic [7:0] FULL     = 8'd255;

  function automatic logic [7:0] wheel_step(input logic [7:0] pos);
    logic [7:0] p;
    p = pos + 8'd1;
    if (p == WHEEL_END) begin
      p = 8'd0;
    end
    return p;
  endfunction

  function automatic rgb_t wheel_color(input logic [7:0] p);
    rgb_t c;
    logic [7:0] q;
    logic [7:0] ramp;
    if (p < SEG_1) begin
      q = p;
    end else if (p < SEG_2) begin
      q = p - SEG_1;
    end else begin
      q = p - SEG_2;
    end
    ramp = 8'((q << 1) + q);
    if (p < SEG_1) begin
      c.red   = ramp;
      c.green = FULL - ramp;
      c.blue  = 8'd0;
    end else if (p < SEG_2) begin
      c.blue  = ramp;
      c.red   = FULL - ramp;
      c.green = 8'd0;
    end else begin
      c.green = ramp;
      c.blue  = FULL - ramp;
      c.red   = 8'd0;
    end
    return c;
  endfunction

  function automatic logic [7:0] step_toward(input logic [7:0] cur, input logic [7:0] tgt);
    logic [7:0] r;
    if (cur > tgt) begin
      r = cur - 8'd1;
    end else if (cur < tgt) begin
      r = cur + 8'd1;
    end else begin
      r = cur;
    end
    return r;
  endfunction

endpackage

FILE: rtl/cwf_dim.sv
`timescale 1ns / 1ps

module cwf_dim (
  input  cwf_pkg::rgb_t                   color,
  input  logic [cwf_pkg::SCALE_W-1:0]     scale,
  output cwf_pkg::rgb_t                   dimmed
);
  import cwf_pkg::*;

  localparam int PROD_W = 8 + SCALE_W;

  logic [PROD_W-1:0] prod_red;
  logic [PROD_W-1:0] prod_green;
  logic [PROD_W-1:0] prod_blue;

  assign prod_red   = PROD_W'(color.red)   * PROD_W'(scale);
  assign prod_green = PROD_W'(color.green) * PROD_W'(scale);
  assign prod_blue  = PROD_W'(color.blue)  * PROD_W'(scale);

  // Rounding error of the scale stays below 0.01 of a unit, so the floor is exact.
  assign dimmed.red   = prod_red[SCALE_SHIFT +: 8];
  assign dimmed.green = prod_green[SCALE_SHIFT +: 8];
  assign dimmed.blue  = prod_blue[SCALE_SHIFT +: 8];

endmodule

FILE: rtl/color_wheel_fader_with_dimming.sv
`timescale 1ns / 1ps

// channel  | handshake            | payload
// ---------+----------------------+----------------------------------
// input    | in_valid / in_stall  | cmd, light_level
// output   | out_valid / out_stall| out_red, out_green, out_blue
// config   | cfg_valid / cfg_ready| fade_period
//
// One item per cycle sustained while the output is not stalled; an accepted item passes
// through the input register, then fade/wheel/dimming logic into the result register.
// Reset (rst, synchronous) clears the pipeline, the color state and sets fade_period to 100.
// A held result stalls the input register; in_stall rises only while both are full.
// cfg_ready is always high.

module color_wheel_fader_with_dimming (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [9:0]  light_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] fade_period
);
  import cwf_pkg::*;

  logic               s1_valid;
  logic               s1_cmd;
  logic [6:0]         s1_goal;

  logic [15:0]        period_limit;
  logic [15:0]        period_count;
  logic [7:0]         wheel_position;
  rgb_t               target;
  rgb_t               current;
  logic [6:0]         brightness_percent;
  logic [SCALE_W-1:0] brightness_scale;

  logic [15:0]        period_count_next;
  logic [7:0]         wheel_position_next;
  rgb_t               target_next;
  rgb_t               current_next;
  logic [6:0]         brightness_percent_next;
  logic [SCALE_W-1:0] brightness_scale_next;
  logic [15:0]        count_inc;
  rgb_t               dimmed;

  logic               in_accept;
  logic               s1_advance;

  logic [10:0]        light_inv;
  logic [17:0]        goal_prod;
  logic [6:0]         goal_raw;
  logic [6:0]         goal;

  assign cfg_ready  = 1'b1;
  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && out_valid && out_stall;
  assign in_accept  = in_valid && !in_stall;

  // Brightness goal: floor((1024 - light) * 100 / 1024), at least 10.
  assign light_inv = 11'd1024 - {1'b0, light_level};
  assign goal_prod = 18'(light_inv) * 18'd100;
  assign goal_raw  = goal_prod[16:10];
  assign goal      = (goal_raw < GOAL_MIN) ? GOAL_MIN : goal_raw;

  always_comb begin
    period_count_next   = period_count;
    wheel_position_next = wheel_position;
    target_next         = target;
    current_next        = current;
    count_inc           = (period_count != 16'hFFFF) ? period_count + 16'd1 : period_count;
    if (s1_cmd == CMD_INIT) begin
      wheel_position_next = wheel_step(wheel_position);
      target_next         = wheel_color(wheel_position_next);
      current_next        = target_next;
    end else if (count_inc >= period_limit) begin
      period_count_next  = 16'd0;
      current_next.red   = step_toward(current.red, target.red);
      current_next.green = step_toward(current.green, target.green);
      current_next.blue  = step_toward(current.blue, target.blue);
      if (current_next == target) begin
        wheel_position_next = wheel_step(wheel_position);
        target_next         = wheel_color(wheel_position_next);
      end
    end else begin
      period_count_next = count_inc;
    end

    brightness_percent_next = brightness_percent;
    brightness_scale_next   = brightness_scale;
    if (s1_goal < brightness_percent) begin
      brightness_percent_next = brightness_percent - 7'd1;
      brightness_scale_next   = brightness_scale - SCALE_STEP;
    end else if (s1_goal > brightness_percent) begin
      brightness_percent_next = brightness_percent + 7'd1;
      brightness_scale_next   = brightness_scale + SCALE_STEP;
    end
  end

  cwf_dim u_dim (
    .color  (current_next),
    .scale  (brightness_scale_next),
    .dimmed (dimmed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid           <= 1'b0;
      out_valid          <= 1'b0;
      period_limit       <= FADE_PERIOD_RESET;
      period_count       <= 16'd0;
      wheel_position     <= 8'd0;
      target             <= '0;
      current            <= '0;
      brightness_percent <= 7'd0;
      brightness_scale   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        period_limit <= fade_period;
      end

      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end

      if (s1_advance) begin
        out_valid          <= 1'b1;
        period_count       <= period_count_next;
        wheel_position     <= wheel_position_next;
        target             <= target_next;
        current            <= current_next;
        brightness_percent <= brightness_percent_next;
        brightness_scale   <= brightness_scale_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd  <= cmd;
      s1_goal <= goal;
    end
    if (s1_advance) begin
      out_red   <= dimmed.red;
      out_green <= dimmed.green;
      out_blue  <= dimmed.blue;
    end
  end

endmodule

FILE: rtl/cwf_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cwf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_red,
  input logic [7:0]  out_green,
  input logic [7:0]  out_blue
);

  logic [23:0] out_rgb;
  logic        out_free;

  assign out_rgb  = {out_red, out_green, out_blue};
  assign out_free = !out_valid || !out_stall;

  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(out_rgb))

  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)

  // The input side only backs up when a result is waiting downstream.
  `ASSERT_CLK(a_stall_cause, clk, rst, in_stall |-> out_valid && out_stall)

  // An accepted item moves into the result register on the next edge once the output frees up.
  `ASSERT_CLK(a_latency, clk, rst, (in_valid && !in_stall) ##1 out_free |=> out_valid)

endmodule

bind color_wheel_fader_with_dimming cwf_checker u_cwf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_red   (out_red),
  .out_green (out_green),
  .out_blue  (out_blue)
);

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import cwf_pkg::*;

  // Tracks the wheel, fade and dimming state and queues the colors that the
  // block should produce, one per accepted item.
  class fade_scoreboard;
    logic [15:0] period;
    logic [15:0] count;
    logic [7:0]  wheel;
    rgb_t        tgt;
    rgb_t        cur;
    int          bright;
    rgb_t        expected[$];
    int          errors;

    function new();
      period = FADE_PERIOD_RESET;
      count = '0;
      wheel = '0;
      tgt = '0;
      cur = '0;
      bright = 0;
      errors = 0;
    endfunction

    function void next_color();
      int p;
      int q;
      p = (int'(wheel) + 1) % 256;
      if (p == 255) begin
        p = 0;
      end
      wheel = 8'(p);
      if (p < 85) begin
        tgt.red = 8'(3 * p);
        tgt.green = 8'(255 - 3 * p);
        tgt.blue = 8'd0;
      end else if (p < 170) begin
        q = p - 85;
        tgt.blue = 8'(3 * q);
        tgt.red = 8'(255 - 3 * q);
        tgt.green = 8'd0;
      end else begin
        q = p - 170;
        tgt.green = 8'(3 * q);
        tgt.blue = 8'(255 - 3 * q);
        tgt.red = 8'd0;
      end
    endfunction

    function logic [7:0] nudge(logic [7:0] c, logic [7:0] t);
      if (c > t) begin
        return c - 8'd1;
      end else if (c < t) begin
        return c + 8'd1;
      end
      return c;
    endfunction

    function void note_item(cmd_t c, logic [9:0] lvl);
      int goal;
      rgb_t r;
      if (c == CMD_INIT) begin
        next_color();
        cur = tgt;
      end else begin
        if (count != 16'hFFFF) begin
          count = count + 16'd1;
        end
        if (count >= period) begin
          count = '0;
          cur.red = nudge(cur.red, tgt.red);
          cur.green = nudge(cur.green, tgt.green);
          cur.blue = nudge(cur.blue, tgt.blue);
          if (cur == tgt) begin
            next_color();
          end
        end
      end
      goal = ((1024 - int'(lvl)) * 100) / 1024;
      if (goal < 10) begin
        goal = 10;
      end
      if (goal < bright) begin
        bright--;
      end else if (goal > bright) begin
        bright++;
      end
      r.red = 8'((int'(cur.red) * bright) / 100);
      r.green = 8'((int'(cur.green) * bright) / 100);
      r.blue = 8'((int'(cur.blue) * bright) / 100);
      expected.push_back(r);
    endfunction

    function void check_result(rgb_t got);
      rgb_t want;
      if (expected.size() == 0) begin
        $display("%0t: unexpected result r=%0d g=%0d b=%0d", $time, got.red, got.green,
                 got.blue);
        errors++;
        return;
      end
      want = expected.pop_front();
      if (got.red !== want.red) begin
        $display("%0t: out_red expected %0d actual %0d", $time, want.red, got.red);
        errors++;
      end
      if (got.green !== want.green) begin
        $display("%0t: out_green expected %0d actual %0d", $time, want.green, got.green);
        errors++;
      end
      if (got.blue !== want.blue) begin
        $display("%0t: out_blue expected %0d actual %0d", $time, want.blue, got.blue);
        errors++;
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        cmd;
  logic [9:0]  light_level;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_period;

  fade_scoreboard sb;
  int results_seen = 0;
  bit dense = 0;

  color_wheel_fader_with_dimming dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .light_level(light_level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .fade_period(cfg_period)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result({out_red, out_green, out_blue});
      results_seen++;
    end
  end

  function automatic int pick_gap();
    int r;
    if (dense) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 30);
  endfunction

  task automatic send_item(cmd_t c, logic [9:0] lvl);
    int gap;
    in_valid <= 1'b1;
    cmd <= c;
    light_level <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(c, lvl);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Let every queued color come out before touching the register.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_period(logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_period <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.period = v;
  endtask

  // Runs of items share a light pattern so brightness can slew to its ends.
  task automatic run_phase(int n);
    int run;
    int mode;
    int i;
    logic [9:0] held;
    logic [9:0] lvl;
    cmd_t c;
    while (n > 0) begin
      run = $urandom_range(15, 90);
      mode = $urandom_range(0, 3);
      held = 10'($urandom_range(0, 1023));
      if (mode == 2) begin
        held = ($urandom_range(0, 1) == 1) ? 10'd1023 : 10'd0;
      end
      dense = ($urandom_range(0, 3) == 0);
      for (i = 0; i < run && n > 0; i++) begin
        lvl = (mode == 1) ? 10'($urandom_range(0, 1023)) : held;
        if ($urandom_range(0, 99) < 35) begin
          c = CMD_INIT;
        end else begin
          c = CMD_UPDATE;
        end
        send_item(c, lvl);
        n--;
      end
    end
    dense = 0;
  endtask

  // Receiver side; one long hold-off partway through fills the pipeline.
  initial begin
    int len;
    int r;
    bit held_off;
    held_off = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held_off && results_seen >= 400) begin
        held_off = 1;
        out_stall <= 1'b1;
        repeat (120) @(posedge clk);
      end else begin
        r = $urandom_range(0, 19);
        if (r < 9) begin
          out_stall <= 1'b0;
          len = $urandom_range(1, 12);
        end else if (r < 11) begin
          out_stall <= 1'b0;
          len = $urandom_range(20, 60);
        end else if (r < 18) begin
          out_stall <= 1'b1;
          len = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          len = $urandom_range(8, 40);
        end
        repeat (len) @(posedge clk);
      end
    end
  end

  initial begin
    logic [15:0] periods [9];
    logic [15:0] p;
    int k;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = 1'b0;
    light_level = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_period = '0;
    periods = '{16'd1, 16'd65535, 16'd2, 16'd0, 16'd3, 16'd0, 16'd100, 16'd0, 16'd7};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset period, goal floor and its boundary
    send_item(CMD_INIT, 10'd0);
    send_item(CMD_UPDATE, 10'd0);
    send_item(CMD_INIT, 10'd1023);
    send_item(CMD_UPDATE, 10'd1023);
    send_item(CMD_INIT, 10'd921);
    send_item(CMD_UPDATE, 10'd922);
    settle();
    // zero period: every update fades, matched colors advance the wheel
    write_period(16'd0);
    send_item(CMD_UPDATE, 10'd512);
    send_item(CMD_UPDATE, 10'd1);
    send_item(CMD_UPDATE, 10'd1022);
    send_item(CMD_UPDATE, 10'd0);
    send_item(CMD_INIT, 10'd0);
    send_item(CMD_UPDATE, 10'd0);
    send_item(CMD_UPDATE, 10'd0);
    send_item(CMD_UPDATE, 10'd0);
    send_item(CMD_UPDATE, 10'd1023);
    send_item(CMD_INIT, 10'd1023);
    send_item(CMD_UPDATE, 10'd1);
    send_item(CMD_UPDATE, 10'd1023);

    for (k = 0; k < 9; k++) begin
      p = (k == 5) ? 16'($urandom_range(4, 40)) : periods[k];
      settle();
      write_period(p);
      run_phase(137);
    end
    settle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/cwf_pkg.sv
rtl/cwf_dim.sv
rtl/color_wheel_fader_with_dimming.sv
rtl/cwf_checker.sv
bench/testbench.sv
